// ===== rtl/grt_pkg.sv =====
// Shared types and constants for the grid row/column rank block.
// No dependencies; imported by the engine, top and testbench.
package grt_pkg;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_COMPUTE = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;

  localparam logic [1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [1:0] CFG_COLUMN_COUNT = 2'd1;

  localparam int        COUNT_W  = 7;
  localparam int        RANK_W   = 13;
  localparam logic [RANK_W-1:0] RANK_MAX = 13'd8191;

  typedef struct packed {
    logic [1:0]         action;
    logic [11:0]        cell_index;
    logic signed [31:0] cell_value;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank_value;
    logic              done_res;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] rows;
    logic [COUNT_W-1:0] cols;
  } eng_ctrl_t;

  typedef enum logic [3:0] {
    E_IDLE,
    E_COPY,
    E_PAIR,
    E_LDA,
    E_LDB,
    E_EMIT,
    E_CLR,
    E_R0,
    E_R1,
    E_R2,
    E_DONE
  } eng_state_t;

endpackage

// ===== rtl/grt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module grt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/grt_engine.sv =====
// Rank engine: copies cell values into a sort buffer, merge-sorts the cells by
// (value, position) in two ping-pong RAMs, then sweeps them in order keeping the
// last rank of each row and column. Depends on grt_pkg and grt_ram.
module grt_engine
  import grt_pkg::*;
#(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  eng_ctrl_t            ctrl,
  output logic                 done,
  output logic                 val_re,
  output logic [((MAX_ROWS * MAX_COLUMNS > 1) ? $clog2(MAX_ROWS * MAX_COLUMNS) : 1)-1:0]
                               val_raddr,
  input  logic [31:0]          val_rdata,
  output logic                 rank_we,
  output logic [((MAX_ROWS * MAX_COLUMNS > 1) ? $clog2(MAX_ROWS * MAX_COLUMNS) : 1)-1:0]
                               rank_waddr,
  output logic [RANK_W-1:0]    rank_wdata
);

  localparam int CELLS = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int EW    = 32 + RW + CW;
  localparam int XW    = AW + 3;

  eng_state_t state_r, state_nxt;

  logic [COUNT_W-1:0] rows_r, cols_r;
  logic [XW-1:0]      n_r, i_r, lo_r, w_r, a_ptr_r, b_ptr_r, k_r, mid_r, hi_r;
  logic [EW-1:0]      head_a_r, head_b_r;
  logic               dir_r, load_b_r;
  logic               d_valid_r;
  logic [AW-1:0]      d_i_r, flat_r;
  logic [RW-1:0]      d_r_r, r_cnt_r, rk_row_r;
  logic [CW-1:0]      d_c_r, c_cnt_r, rk_col_r;
  logic [COUNT_W-1:0] clr_r;

  // Sort buffer ports seen as source and destination of the current pass.
  logic               src_re, dst_we;
  logic [AW-1:0]      src_raddr, dst_waddr;
  logic [EW-1:0]      src_rdata, dst_wdata;
  logic               m0_we, m1_we, m0_re, m1_re;
  logic [AW-1:0]      m0_waddr;
  logic [EW-1:0]      m0_wdata, m0_rdata, m1_rdata;

  logic               rl_we, cl_we, rl_re, cl_re;
  logic [RW-1:0]      rl_waddr, rl_raddr;
  logic [CW-1:0]      cl_waddr, cl_raddr;
  logic [RANK_W-1:0]  rl_wdata, cl_wdata, rl_rdata, cl_rdata;

  logic [XW-1:0]      lo_w, lo_2w, mid_c, hi_c, w_dbl;
  logic               a_has, b_has, take_a, a_less;
  logic [EW-1:0]      take_ent;
  logic [RANK_W-1:0]  max_rank, new_rank;
  logic [COUNT_W:0]   clr_len;
  logic [RW-1:0]      ent_row;
  logic [CW-1:0]      ent_col;

  assign lo_w   = lo_r + w_r;
  assign lo_2w  = lo_r + (w_r << 1);
  assign w_dbl  = w_r << 1;
  assign mid_c  = (lo_w < n_r) ? lo_w : n_r;
  assign hi_c   = (lo_2w < n_r) ? lo_2w : n_r;
  assign a_has  = a_ptr_r < mid_r;
  assign b_has  = b_ptr_r < hi_r;

  // Positions are unique, so the key order is strict.
  always_comb begin
    if ($signed(head_a_r[EW-1 -: 32]) != $signed(head_b_r[EW-1 -: 32])) begin
      a_less = $signed(head_a_r[EW-1 -: 32]) < $signed(head_b_r[EW-1 -: 32]);
    end else begin
      a_less = head_a_r[RW+CW-1:0] < head_b_r[RW+CW-1:0];
    end
  end

  assign take_a   = a_has && (!b_has || a_less);
  assign take_ent = take_a ? head_a_r : head_b_r;
  assign max_rank = (rl_rdata > cl_rdata) ? rl_rdata : cl_rdata;
  assign new_rank = (max_rank == RANK_MAX) ? RANK_MAX : max_rank + 1'b1;
  assign clr_len  = (rows_r > cols_r) ? {1'b0, rows_r} : {1'b0, cols_r};
  assign ent_row  = src_rdata[CW +: RW];
  assign ent_col  = src_rdata[CW-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      E_IDLE: begin
        if (ctrl.start) state_nxt = E_COPY;
      end
      E_COPY: begin
        if (i_r >= n_r && !d_valid_r) begin
          state_nxt = (n_r > XW'(1)) ? E_PAIR : E_CLR;
        end
      end
      E_PAIR: state_nxt = E_LDA;
      E_LDA: begin
        state_nxt = (load_b_r && b_ptr_r < hi_r) ? E_LDB : E_EMIT;
      end
      E_LDB: state_nxt = E_EMIT;
      E_EMIT: begin
        if (!a_has && !b_has) begin
          if (lo_2w >= n_r) begin
            state_nxt = (w_dbl < n_r) ? E_PAIR : E_CLR;
          end else begin
            state_nxt = E_PAIR;
          end
        end else if (take_a) begin
          state_nxt = (a_ptr_r + 1'b1 < mid_r) ? E_LDA : E_EMIT;
        end else begin
          state_nxt = (b_ptr_r + 1'b1 < hi_r) ? E_LDB : E_EMIT;
        end
      end
      E_CLR: begin
        if ({1'b0, clr_r} + 1'b1 >= clr_len) state_nxt = E_R0;
      end
      E_R0: state_nxt = E_R1;
      E_R1: state_nxt = E_R2;
      E_R2: begin
        state_nxt = (k_r + 1'b1 >= n_r) ? E_DONE : E_R0;
      end
      E_DONE: state_nxt = E_IDLE;
      default: state_nxt = E_IDLE;
    endcase
  end

  always_comb begin
    done       = 1'b0;
    val_re     = 1'b0;
    val_raddr  = i_r[AW-1:0];
    src_re     = 1'b0;
    src_raddr  = lo_r[AW-1:0];
    dst_we     = 1'b0;
    dst_waddr  = k_r[AW-1:0];
    dst_wdata  = take_ent;
    rl_we      = 1'b0;
    cl_we      = 1'b0;
    rl_waddr   = clr_r[RW-1:0];
    cl_waddr   = clr_r[CW-1:0];
    rl_wdata   = '0;
    cl_wdata   = '0;
    rl_re      = 1'b0;
    cl_re      = 1'b0;
    rl_raddr   = ent_row;
    cl_raddr   = ent_col;
    rank_we    = 1'b0;
    rank_waddr = flat_r;
    rank_wdata = new_rank;
    unique case (state_r)
      E_COPY: begin
        val_re = i_r < n_r;
      end
      E_PAIR: begin
        src_re = 1'b1;
      end
      E_LDA: begin
        src_re    = load_b_r && b_ptr_r < hi_r;
        src_raddr = b_ptr_r[AW-1:0];
      end
      E_EMIT: begin
        if (a_has || b_has) begin
          dst_we = 1'b1;
          if (take_a) begin
            src_re    = a_ptr_r + 1'b1 < mid_r;
            src_raddr = AW'(a_ptr_r + 1'b1);
          end else begin
            src_re    = b_ptr_r + 1'b1 < hi_r;
            src_raddr = AW'(b_ptr_r + 1'b1);
          end
        end
      end
      E_CLR: begin
        rl_we = clr_r < rows_r;
        cl_we = clr_r < cols_r;
      end
      E_R0: begin
        src_re    = 1'b1;
        src_raddr = k_r[AW-1:0];
      end
      E_R1: begin
        rl_re = 1'b1;
        cl_re = 1'b1;
      end
      E_R2: begin
        rl_we    = 1'b1;
        cl_we    = 1'b1;
        rl_waddr = rk_row_r;
        cl_waddr = rk_col_r;
        rl_wdata = new_rank;
        cl_wdata = new_rank;
        rank_we  = 1'b1;
      end
      E_DONE: begin
        done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
      dir_r     <= 1'b0;
      load_b_r  <= 1'b0;
    end else begin
      case (state_r)
        E_IDLE: begin
          if (ctrl.start) begin
            rows_r    <= ctrl.rows;
            cols_r    <= ctrl.cols;
            n_r       <= XW'(ctrl.rows) * XW'(ctrl.cols);
            i_r       <= '0;
            r_cnt_r   <= '0;
            c_cnt_r   <= '0;
            d_valid_r <= 1'b0;
            dir_r     <= 1'b0;
            lo_r      <= '0;
            w_r       <= XW'(1);
            clr_r     <= '0;
            k_r       <= '0;
          end
        end
        E_COPY: begin
          d_valid_r <= i_r < n_r;
          d_i_r     <= i_r[AW-1:0];
          d_r_r     <= r_cnt_r;
          d_c_r     <= c_cnt_r;
          if (i_r < n_r) begin
            i_r <= i_r + 1'b1;
            if (32'(c_cnt_r) == 32'(cols_r) - 1) begin
              c_cnt_r <= '0;
              r_cnt_r <= r_cnt_r + 1'b1;
            end else begin
              c_cnt_r <= c_cnt_r + 1'b1;
            end
          end
        end
        E_PAIR: begin
          mid_r    <= mid_c;
          hi_r     <= hi_c;
          a_ptr_r  <= lo_r;
          b_ptr_r  <= mid_c;
          k_r      <= lo_r;
          load_b_r <= 1'b1;
        end
        E_LDA: begin
          head_a_r <= src_rdata;
          load_b_r <= 1'b0;
        end
        E_LDB: begin
          head_b_r <= src_rdata;
        end
        E_EMIT: begin
          if (!a_has && !b_has) begin
            if (lo_2w >= n_r) begin
              lo_r  <= '0;
              w_r   <= w_dbl;
              dir_r <= ~dir_r;
              k_r   <= '0;
            end else begin
              lo_r <= lo_2w;
            end
          end else begin
            k_r <= k_r + 1'b1;
            if (take_a) begin
              a_ptr_r <= a_ptr_r + 1'b1;
            end else begin
              b_ptr_r <= b_ptr_r + 1'b1;
            end
          end
        end
        E_CLR: begin
          clr_r <= clr_r + 1'b1;
          k_r   <= '0;
        end
        E_R1: begin
          rk_row_r <= ent_row;
          rk_col_r <= ent_col;
          flat_r   <= AW'(XW'(ent_row) * XW'(cols_r) + XW'(ent_col));
        end
        E_R2: begin
          k_r <= k_r + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // The copy pass always fills buffer 0, which is then the first source.
  always_comb begin
    m0_we     = (state_r == E_COPY && d_valid_r) || (dir_r && dst_we);
    m0_waddr  = (state_r == E_COPY) ? d_i_r : dst_waddr;
    m0_wdata  = (state_r == E_COPY) ? {val_rdata, d_r_r, d_c_r} : dst_wdata;
    m1_we     = !dir_r && dst_we;
    m0_re     = !dir_r && src_re;
    m1_re     = dir_r && src_re;
    src_rdata = dir_r ? m1_rdata : m0_rdata;
  end

  grt_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_buf0 (
    .clk   (clk),
    .we    (m0_we),
    .waddr (m0_waddr),
    .wdata (m0_wdata),
    .re    (m0_re),
    .raddr (src_raddr),
    .rdata (m0_rdata)
  );

  grt_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_buf1 (
    .clk   (clk),
    .we    (m1_we),
    .waddr (dst_waddr),
    .wdata (dst_wdata),
    .re    (m1_re),
    .raddr (src_raddr),
    .rdata (m1_rdata)
  );

  grt_ram #(.WIDTH(RANK_W), .DEPTH(MAX_ROWS)) u_row_last (
    .clk   (clk),
    .we    (rl_we),
    .waddr (rl_waddr),
    .wdata (rl_wdata),
    .re    (rl_re),
    .raddr (rl_raddr),
    .rdata (rl_rdata)
  );

  grt_ram #(.WIDTH(RANK_W), .DEPTH(MAX_COLUMNS)) u_col_last (
    .clk   (clk),
    .we    (cl_we),
    .waddr (cl_waddr),
    .wdata (cl_wdata),
    .re    (cl_re),
    .raddr (cl_raddr),
    .rdata (cl_rdata)
  );

endmodule

// ===== rtl/grid_row_column_rank_top.sv =====
// Top level of the grid row/column rank block: request intake, configuration,
// cell value and rank RAMs, result staging. Depends on grt_pkg, grt_ram, grt_engine.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready  | in_item_t
//   out_    | output    | out_valid / out_ready| out_item_t
//   cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A new write or read request can be taken while the previous result moves on;
// results pass through a staging register and then the output register.
// A compute request copies the cell values, merges pairs of runs over ceil(log2 n)
// passes, clears the row and column lines, sweeps the sorted cells for ranks and
// then reports done, n = rows * columns; each sort buffer has a single read port.
// Intake stalls for the whole compute; one result may wait in a staging register
// while the output is stalled. Reset is synchronous and clears control state only.
module grid_row_column_rank_top
  import grt_pkg::*;
#(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [COUNT_W-1:0] cfg_data
);

  localparam int CELLS = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic [COUNT_W-1:0]   rows_r, cols_r, cfg_v;
  logic [2*COUNT_W-1:0] n_c;
  logic                 busy_r, in_fire, idx_ok, s1_move;
  logic                 s1_valid_r, s1_read_r, s1_done_r, out_valid_r;
  out_item_t            out_data_r;
  eng_ctrl_t            ctrl;
  logic                 eng_done, val_re, rank_we;
  logic [AW-1:0]        val_raddr, rank_waddr;
  logic [31:0]          val_rdata;
  logic [RANK_W-1:0]    rank_wdata, rank_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_v     = (cfg_data == '0) ? COUNT_W'(1) : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= COUNT_W'((MAX_ROWS < 64) ? MAX_ROWS : 64);
      cols_r <= COUNT_W'((MAX_COLUMNS < 64) ? MAX_COLUMNS : 64);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ROW_COUNT: begin
          rows_r <= (32'(cfg_v) > MAX_ROWS) ? COUNT_W'(MAX_ROWS) : cfg_v;
        end
        CFG_COLUMN_COUNT: begin
          cols_r <= (32'(cfg_v) > MAX_COLUMNS) ? COUNT_W'(MAX_COLUMNS) : cfg_v;
        end
        default: begin
        end
      endcase
    end
  end

  assign n_c      = (2*COUNT_W)'(rows_r) * (2*COUNT_W)'(cols_r);
  assign idx_ok   = 32'(in_data.cell_index) < 32'(n_c);
  assign s1_move  = !out_valid_r || out_ready;
  assign in_ready = !busy_r && (!s1_valid_r || s1_move);
  assign in_fire  = in_valid && in_ready;

  assign ctrl = '{start: in_fire && in_data.action == ACT_COMPUTE,
                  rows: rows_r, cols: cols_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.start) begin
        busy_r <= 1'b1;
      end else if (eng_done) begin
        busy_r <= 1'b0;
      end

      if (in_fire && in_data.action != ACT_COMPUTE) begin
        s1_valid_r <= 1'b1;
        s1_read_r  <= in_data.action == ACT_READ && idx_ok;
        s1_done_r  <= (in_data.action == ACT_READ || in_data.action == ACT_WRITE) && idx_ok;
      end else if (eng_done) begin
        s1_valid_r <= 1'b1;
        s1_read_r  <= 1'b0;
        s1_done_r  <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end

      // The rank RAM read data holds until the next read request.
      if (s1_valid_r && s1_move) begin
        out_valid_r           <= 1'b1;
        out_data_r.rank_value <= s1_read_r ? rank_rdata : '0;
        out_data_r.done_res   <= s1_done_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  grt_ram #(.WIDTH(32), .DEPTH(CELLS)) u_values (
    .clk   (clk),
    .we    (in_fire && in_data.action == ACT_WRITE && idx_ok),
    .waddr (AW'(in_data.cell_index)),
    .wdata (in_data.cell_value),
    .re    (val_re),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  grt_ram #(.WIDTH(RANK_W), .DEPTH(CELLS)) u_ranks (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rank_waddr),
    .wdata (rank_wdata),
    .re    (in_fire && in_data.action == ACT_READ),
    .raddr (AW'(in_data.cell_index)),
    .rdata (rank_rdata)
  );

  grt_engine #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .done       (eng_done),
    .val_re     (val_re),
    .val_raddr  (val_raddr),
    .val_rdata  (val_rdata),
    .rank_we    (rank_we),
    .rank_waddr (rank_waddr),
    .rank_wdata (rank_wdata)
  );

endmodule

// ===== tb/tb_grid_row_column_rank_top.sv =====
// Self-checking testbench for grid_row_column_rank_top: drives write, compute and
// read requests plus configuration writes, predicts every result. Depends on grt_pkg.
`timescale 1ns / 1ps

module tb_grid_row_column_rank_top;
  import grt_pkg::*;

  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam logic [1:0] CFG_SPARE_2  = 2'd2;
  localparam logic [1:0] CFG_SPARE_3  = 2'd3;
  localparam int         CELL_DEPTH   = 4096;
  localparam int         SIDE_MAX     = 64;
  localparam int         SETTLE_CYC   = 20;
  localparam int         CYCLE_LIMIT  = 3000000;

  typedef struct packed {
    logic [1:0]         idx;
    logic [COUNT_W-1:0] data;
  } cfg_req_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [COUNT_W-1:0] cfg_data;

  grid_row_column_rank_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the block's state.
  logic signed [31:0] grid_val [CELL_DEPTH];
  int                 grid_rank [CELL_DEPTH];
  int                 grid_rows;
  int                 grid_cols;

  in_item_t  request_q [$];
  cfg_req_t  cfg_q [$];
  out_item_t result_q [$];
  int        idle_pct;
  int        fail_count;
  int        cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit cell_precedes(int a, int b);
    if (grid_val[a] != grid_val[b]) return grid_val[a] < grid_val[b];
    return a < b;
  endfunction

  // Rank transform of the active grid: link lines in sorted order, then a
  // topological walk that takes the longest path into each cell.
  function automatic void rank_grid();
    int n;
    int line [SIDE_MAX];
    int row_next [CELL_DEPTH];
    int col_next [CELL_DEPTH];
    int indeg [CELL_DEPTH];
    int walk [$];
    int len, start, stride, c, m, u, v, r, pass, lines;
    n = grid_rows * grid_cols;
    for (int i = 0; i < n; i++) begin
      row_next[i] = -1;
      col_next[i] = -1;
      indeg[i] = 0;
      grid_rank[i] = 1;
    end
    for (pass = 0; pass < 2; pass++) begin
      lines = (pass == 0) ? grid_rows : grid_cols;
      len = (pass == 0) ? grid_cols : grid_rows;
      stride = (pass == 0) ? 1 : grid_cols;
      for (int l = 0; l < lines; l++) begin
        start = (pass == 0) ? l * grid_cols : l;
        for (int k = 0; k < len; k++) begin
          c = start + k * stride;
          m = k;
          while (m > 0 && cell_precedes(c, line[m-1])) begin
            line[m] = line[m-1];
            m--;
          end
          line[m] = c;
        end
        for (int k = 1; k < len; k++) begin
          if (pass == 0) row_next[line[k-1]] = line[k];
          else col_next[line[k-1]] = line[k];
          indeg[line[k]]++;
        end
      end
    end
    for (int i = 0; i < n; i++) if (indeg[i] == 0) walk.insert(walk.size(), i);
    while (walk.size() > 0) begin
      u = walk.pop_front();
      for (pass = 0; pass < 2; pass++) begin
        v = (pass == 0) ? row_next[u] : col_next[u];
        if (v >= 0) begin
          r = grid_rank[u] + 1;
          if (r > RANK_MAX) r = RANK_MAX;
          if (r > grid_rank[v]) grid_rank[v] = r;
          indeg[v]--;
          if (indeg[v] == 0) walk.insert(walk.size(), v);
        end
      end
    end
  endfunction

  function automatic out_item_t predict_result(in_item_t req);
    out_item_t res;
    int n;
    n = grid_rows * grid_cols;
    res = '0;
    case (req.action)
      ACT_WRITE: begin
        if (req.cell_index < n) begin
          grid_val[req.cell_index] = req.cell_value;
          res.done_res = 1'b1;
        end
      end
      ACT_COMPUTE: begin
        rank_grid();
        res.done_res = 1'b1;
      end
      ACT_READ: begin
        if (req.cell_index < n) begin
          res.rank_value = RANK_W'(grid_rank[req.cell_index]);
          res.done_res = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int clamp_count(logic [COUNT_W-1:0] data);
    int v;
    v = (data == 0) ? 1 : int'(data);
    return (v > SIDE_MAX) ? SIDE_MAX : v;
  endfunction

  // Request and configuration driver; predictions are made on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) result_q.insert(result_q.size(), predict_result(in_data));
      if (!in_valid || in_ready) begin
        if (request_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_data <= request_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ROW_COUNT) grid_rows = clamp_count(cfg_data);
        else if (cfg_index == CFG_COLUMN_COUNT) grid_cols = clamp_count(cfg_data);
      end
      if (!cfg_valid || cfg_ready) begin
        if (cfg_q.size() > 0) begin
          cfg_valid <= 1'b1;
          {cfg_index, cfg_data} <= cfg_q.pop_front();
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random backpressure.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result rank=%0d done=%0b", $time,
                   out_data.rank_value, out_data.done_res);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (out_data.rank_value !== want.rank_value) begin
            $display("%0t: rank_value expected %0d actual %0d", $time,
                     want.rank_value, out_data.rank_value);
            fail_count++;
          end
          if (out_data.done_res !== want.done_res) begin
            $display("%0t: done_res expected %0b actual %0b", $time,
                     want.done_res, out_data.done_res);
            fail_count++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send(logic [1:0] act, int idx, logic [31:0] val);
    in_item_t req;
    req.action = act;
    req.cell_index = idx[11:0];
    req.cell_value = val;
    request_q.insert(request_q.size(), req);
  endtask

  // Waits until every request has been answered and the block has settled.
  task automatic drain();
    @(posedge clk);
    while (request_q.size() > 0 || in_valid || result_q.size() > 0
           || cfg_q.size() > 0 || cfg_valid)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_shape(int rows, int cols);
    drain();
    cfg_q.insert(cfg_q.size(), {CFG_ROW_COUNT, rows[COUNT_W-1:0]});
    cfg_q.insert(cfg_q.size(), {CFG_COLUMN_COUNT, cols[COUNT_W-1:0]});
    drain();
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 1)) return $urandom();
    return $urandom_range(0, 4) - 2;
  endfunction

  initial begin
    int n, rows, cols, roll;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 12;
    fail_count = 0;
    cycle_count = 0;
    grid_rows = SIDE_MAX;
    grid_cols = SIDE_MAX;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // A saturating column count gives a 1x64 grid. Its 64 cells are filled here,
    // and no later shape uses more cells, so every compute and read stays defined.
    set_shape(1, 127);
    for (int i = 0; i < SIDE_MAX; i++)
      send(ACT_WRITE, i, (i % 7 == 0) ? $urandom() : $urandom_range(0, 3));
    send(ACT_WRITE, 0, 32'h8000_0000);
    send(ACT_WRITE, 1, 32'h7fff_ffff);
    send(ACT_WRITE, SIDE_MAX - 1, 32'hffff_ffff);
    send(ACT_UNUSED, 5, 32'h1234_5678);
    send(ACT_COMPUTE, 0, 0);
    send(ACT_READ, 0, 0);
    send(ACT_READ, 1, 0);
    send(ACT_READ, SIDE_MAX - 1, 0);
    send(ACT_READ, 4095, 0);

    // A saturating row count turns the same cells into one 64-row column.
    set_shape(127, 1);
    send(ACT_COMPUTE, 0, 0);
    send(ACT_READ, 0, 0);
    send(ACT_READ, SIDE_MAX - 1, 0);

    // Zero counts become one; spare register indexes are ignored.
    set_shape(0, 3);
    cfg_q.insert(cfg_q.size(), {CFG_SPARE_2, 7'd5});
    cfg_q.insert(cfg_q.size(), {CFG_SPARE_3, 7'd127});
    drain();
    send(ACT_WRITE, 0, 32'd7);
    send(ACT_WRITE, 1, 32'd7);
    send(ACT_WRITE, 2, 32'hffff_fff9);
    send(ACT_WRITE, 3, 32'd1);
    send(ACT_READ, 3, 0);
    send(ACT_READ, 4095, 0);
    send(ACT_COMPUTE, 0, 0);
    for (int i = 0; i < 3; i++) send(ACT_READ, i, 0);

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin rows = 1; cols = 64; end
        1: begin rows = 64; cols = 1; end
        2: begin rows = 8; cols = 8; end
        default: begin
          rows = $urandom_range(1, 8);
          cols = $urandom_range(1, 8);
        end
      endcase
      set_shape(rows, cols);
      idle_pct = (phase == 3) ? 0 : 12;
      n = rows * cols;
      for (int k = 0; k < 85; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 55)
          send(ACT_WRITE, (roll < 48) ? $urandom_range(0, n - 1)
                                      : $urandom_range(n, 4095), pick_value());
        else if (roll < 85)
          send(ACT_READ, (roll < 80) ? $urandom_range(0, n - 1)
                                     : $urandom_range(n, 4095), $urandom());
        else if (roll < 96)
          send(ACT_COMPUTE, $urandom_range(0, 4095), $urandom());
        else
          send(ACT_UNUSED, $urandom_range(0, 4095), $urandom());
      end
      send(ACT_COMPUTE, 0, 0);
      for (int i = 0; i < n; i++) send(ACT_READ, i, 0);
    end

    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
